@@ src/b2bcd_pkg.sv @@
// ----------------------------------------------------------------------------
// b2bcd_pkg
// Shared types and constants for the binary to BCD converter.
// ----------------------------------------------------------------------------
package b2bcd_pkg;

  // Widths of the binary input and the packed BCD output
  localparam int BIN_W       = 64;
  localparam int BCD_W       = 64;

  // Digits needed for any 64-bit value, and width of the full BCD register
  localparam int FULL_DIGITS = 20;
  localparam int FULL_BCD_W  = 4 * FULL_DIGITS;

  // Default count of digits kept in the result
  localparam int DIGITS_DEF  = 16;

  // Shift counter covers one step per input bit
  localparam int CNT_W       = $clog2(BIN_W);

  // Controller states
  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_SHIFT,
    CTL_DONE
  } ctl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic shift;
    logic capture;
  } dp_cmd_t;

endpackage

@@ src/b2bcd_datapath.sv @@
// ----------------------------------------------------------------------------
// b2bcd_datapath
// Shift-add-3 datapath: binary shift register, full BCD register and the
// output payload registers.
// ----------------------------------------------------------------------------
module b2bcd_datapath #(
  parameter int DIGITS = b2bcd_pkg::DIGITS_DEF
) (
  input  logic                         clk,
  input  b2bcd_pkg::dp_cmd_t           cmd,
  input  logic [b2bcd_pkg::BIN_W-1:0]  bin_value,
  output logic [b2bcd_pkg::BCD_W-1:0]  bcd_digits,
  output logic                         overflow
);
  import b2bcd_pkg::*;

  localparam int KEEP_W = 4 * DIGITS;

  logic [BIN_W-1:0]      bin_r;
  logic [FULL_BCD_W-1:0] bcd_r;
  logic [FULL_BCD_W-1:0] bcd_adj;
  logic [BCD_W-1:0]      bcd_kept;
  logic [BCD_W-1:0]      out_bcd_r;
  logic                  out_ovf_r;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < FULL_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  // Keep the low digits, zero the rest
  always_comb begin
    for (int i = 0; i < BCD_W / 4; i++) begin
      if (i < DIGITS) begin
        bcd_kept[4*i +: 4] = bcd_r[4*i +: 4];
      end else begin
        bcd_kept[4*i +: 4] = 4'd0;
      end
    end
  end

  // Load the operand, then shift one bit into the BCD register per step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r <= bin_value;
      bcd_r <= '0;
    end else if (cmd.shift) begin
      bcd_r <= {bcd_adj[FULL_BCD_W-2:0], bin_r[BIN_W-1]};
      bin_r <= {bin_r[BIN_W-2:0], 1'b0};
    end
  end

  // Capture the finished result into the output register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_bcd_r <= bcd_kept;
      out_ovf_r <= |bcd_r[FULL_BCD_W-1:KEEP_W];
    end
  end

  assign bcd_digits = out_bcd_r;
  assign overflow   = out_ovf_r;

endmodule

@@ src/b2bcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// b2bcd_ctrl
// Controller: input and output handshakes, shift step counter and the
// sequencing of load, shift and capture.
// ----------------------------------------------------------------------------
module b2bcd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output b2bcd_pkg::dp_cmd_t  cmd
);
  import b2bcd_pkg::*;

  ctl_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Hold the state, counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CTL_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    in_stall      = 1'b1;
    case (state_r)
      CTL_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = CTL_SHIFT;
        end
      end
      CTL_SHIFT: begin
        cmd.shift = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(BIN_W - 1)) begin
          state_nxt = CTL_DONE;
        end
      end
      CTL_DONE: begin
        // Wait until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.capture   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = CTL_IDLE;
        end
      end
      default: begin
        state_nxt = CTL_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  // A new operand always starts a fresh count of shift steps
  a_start_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == CTL_SHIFT && cnt_r == '0))
    else $error("conversion did not start with a cleared step count");

  // A result appears only after the last shift step
  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == CTL_DONE))
    else $error("result raised outside the done state");

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> (!out_valid_r || !out_stall))
    else $error("pending result overwritten");

  // The last shift step always leads to the done state
  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CTL_SHIFT && cnt_r == CNT_W'(BIN_W - 1)) |=> (state_r == CTL_DONE))
    else $error("shift sequence did not end after the last step");

endmodule

@@ src/binary_to_bcd_converter.sv @@
// An accepted operand is converted by 64 shift-add-3 steps, one per input bit, then
// captured into the output register once that register is free.
// The idle state accepts the next operand only after that capture.
// The next input is taken while a finished result waits in the output register.
// Reset (rst_n, synchronous, active low) clears the controller and out_valid.
// ----------------------------------------------------------------------------
// binary_to_bcd_converter
// Unsigned 64-bit binary to packed BCD conversion with overflow flag.
// ----------------------------------------------------------------------------
module binary_to_bcd_converter #(
  parameter int DIGITS = b2bcd_pkg::DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [b2bcd_pkg::BIN_W-1:0]  in_bin_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [b2bcd_pkg::BCD_W-1:0]  out_bcd_digits,
  output logic                         out_overflow
);
  import b2bcd_pkg::*;

  dp_cmd_t cmd;

  // Sequence the conversion
  b2bcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Shift-add-3 datapath and output register
  b2bcd_datapath #(
    .DIGITS (DIGITS)
  ) u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .bin_value  (in_bin_value),
    .bcd_digits (out_bcd_digits),
    .overflow   (out_overflow)
  );

endmodule

@@ verif/tb_binary_to_bcd_converter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_to_bcd_converter
// Self-checking bench for the binary to packed BCD converter. A directed
// table covers zero, digit boundaries, powers of ten, the largest value
// that fits and the overflow cases. Random values of mixed magnitude follow
// under three flow-control phases. Every result is compared against a typed
// expectation or a digit-by-digit division predictor in transaction order.
// ----------------------------------------------------------------------------
module tb_binary_to_bcd_converter;
  import b2bcd_pkg::*;

  localparam int DIGITS      = DIGITS_DEF;
  localparam int KEPT        = (DIGITS > 16) ? 16 : DIGITS;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 70;
  localparam int N_PHASE0    = 180;
  localparam int N_PHASE1    = 180;
  localparam int N_PHASE2    = 190;

  typedef struct {
    logic [BCD_W-1:0] bcd;
    logic             ovf;
  } bcd_result_t;

  typedef struct {
    logic [BIN_W-1:0] value;
    bit               typed;
    logic [BCD_W-1:0] bcd;
    logic             ovf;
  } dir_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [BIN_W-1:0] in_bin_value;
  logic             out_valid;
  logic             out_stall;
  logic [BCD_W-1:0] out_bcd_digits;
  logic             out_overflow;

  bcd_result_t pending_bcd_q[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_req;
  int          n_errors;
  int          n_checked;
  int          n_ovf;

  binary_to_bcd_converter #(.DIGITS(DIGITS)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_bin_value   (in_bin_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_bcd_digits (out_bcd_digits),
    .out_overflow   (out_overflow)
  );

  // Directed rows: typed results only where they are obvious
  dir_row_t dir_rows[20] = '{
    '{64'd0,                    1'b1, 64'h0,                 1'b0},
    '{64'd1,                    1'b1, 64'h1,                 1'b0},
    '{64'd9,                    1'b1, 64'h9,                 1'b0},
    '{64'd10,                   1'b1, 64'h10,                1'b0},
    '{64'd99,                   1'b1, 64'h99,                1'b0},
    '{64'd100,                  1'b1, 64'h100,               1'b0},
    '{64'd9999999999999999,     1'b1, 64'h9999999999999999,  1'b0},
    '{64'd10000000000000000,    1'b1, 64'h0,                 1'b1},
    '{64'd10000000000000001,    1'b1, 64'h1,                 1'b1},
    '{64'd10000000000000000000, 1'b1, 64'h0,                 1'b1},
    '{64'hFFFFFFFFFFFFFFFF,     1'b1, 64'h6744073709551615,  1'b1},
    '{64'h5555555555555555,     1'b0, 64'h0,                 1'b0},
    '{64'hAAAAAAAAAAAAAAAA,     1'b0, 64'h0,                 1'b0},
    '{64'h8000000000000000,     1'b0, 64'h0,                 1'b0},
    '{64'h0020000000000000,     1'b0, 64'h0,                 1'b0},
    '{64'h00000000FFFFFFFF,     1'b0, 64'h0,                 1'b0},
    '{64'h0000000100000000,     1'b0, 64'h0,                 1'b0},
    '{64'd999999999999999,      1'b0, 64'h0,                 1'b0},
    '{64'd12345678901234567,    1'b0, 64'h0,                 1'b0},
    '{64'd1234567890123456,     1'b0, 64'h0,                 1'b0}
  };

  // Peel off decimal digits, low first; anything left over is overflow
  function automatic bcd_result_t bcd_of(input logic [BIN_W-1:0] value);
    bcd_result_t      r;
    logic [BIN_W-1:0] rest;
    logic [BIN_W-1:0] digit;
    rest  = value;
    r.bcd = '0;
    for (int i = 0; i < KEPT; i++) begin
      digit = rest % 64'd10;
      rest  = rest / 64'd10;
      r.bcd[4*i +: 4] = digit[3:0];
    end
    r.ovf = (rest != 0);
    return r;
  endfunction

  function automatic logic [BIN_W-1:0] pow10(input int n);
    logic [BIN_W-1:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 64'd10;
    return p;
  endfunction

  // Mix full-width, short, near-power-of-ten and in-range values
  function automatic logic [BIN_W-1:0] rand_bin();
    logic [BIN_W-1:0] full;
    int               kind;
    int               w;
    full = {$urandom, $urandom};
    kind = $urandom_range(0, 9);
    if (kind <= 2) begin
      return full;
    end else if (kind <= 5) begin
      w = $urandom_range(1, 64);
      return full >> (64 - w);
    end else if (kind <= 7) begin
      return pow10($urandom_range(0, 19)) + 64'($urandom_range(0, 4)) - 64'd2;
    end else begin
      return full % pow10(16);
    end
  endfunction

  // Offer one transaction, hold it through stalls, record its expectation
  task automatic send_bin(input logic [BIN_W-1:0] value, input bit typed,
                          input bcd_result_t typed_res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_bin_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_bcd_q.push_back(typed ? typed_res : bcd_of(value));
  endtask

  // Drop valid and wait until every result has been drained
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bcd_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(input int count, input int hold_at);
    bcd_result_t none;
    none = '{bcd: '0, ovf: 1'b0};
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      send_bin(rand_bin(), 1'b0, none);
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: check accepted transactions, drive random and long stalls
  initial begin
    int          hold_left;
    bcd_result_t exp_res;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_bcd_q.size() == 0) begin
          $error("unexpected result: bcd_digits %h overflow %b",
                 out_bcd_digits, out_overflow);
          n_errors++;
        end else begin
          exp_res = pending_bcd_q.pop_front();
          n_checked++;
          if (exp_res.ovf) n_ovf++;
          if (out_bcd_digits !== exp_res.bcd) begin
            $error("bcd_digits: expected %h actual %h", exp_res.bcd, out_bcd_digits);
            n_errors++;
          end
          if (out_overflow !== exp_res.ovf) begin
            $error("overflow: expected %b actual %b", exp_res.ovf, out_overflow);
            n_errors++;
          end
        end
      end
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Stimulus
  initial begin
    bcd_result_t typed_res;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_bin_value  = '0;
    hold_req      = 1'b0;
    n_errors      = 0;
    n_checked     = 0;
    n_ovf         = 0;
    send_idle_pct = 14;
    recv_idle_pct = 46;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      typed_res = '{bcd: dir_rows[i].bcd, ovf: dir_rows[i].ovf};
      send_bin(dir_rows[i].value, dir_rows[i].typed, typed_res);
    end

    // Sender lightly idle, receiver heavily stalled, one long hold-off
    send_random(N_PHASE0, 40);
    drain();

    // Swap the idle rates
    send_idle_pct = 46;
    recv_idle_pct = 14;
    send_random(N_PHASE1, -1);
    drain();

    // Back-to-back, no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(N_PHASE2, -1);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d conversions (%0d overflowing) over three flow-control phases,",
             n_checked, n_ovf);
    $display("including a %0d-cycle output hold-off with the input backed up.", HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", pending_bcd_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
